// ----- src/tesp_pkg.sv -----
`timescale 1ns / 1ps
package tesp_pkg;

	localparam int PARAM_SLOTS = 16;
	localparam int SLOT_W = $clog2(PARAM_SLOTS);
	localparam int CNT_W = $clog2(PARAM_SLOTS + 1);

	localparam logic [3:0] K_PRINT = 4'd0;
	localparam logic [3:0] K_EXEC = 4'd1;
	localparam logic [3:0] K_ESC = 4'd2;
	localparam logic [3:0] K_CSI = 4'd3;
	localparam logic [3:0] K_HOOK = 4'd4;
	localparam logic [3:0] K_PUT = 4'd5;
	localparam logic [3:0] K_UNHOOK = 4'd6;
	localparam logic [3:0] K_OSC_DATA = 4'd7;
	localparam logic [3:0] K_OSC_END = 4'd8;

	// parser states
	localparam logic [3:0] S_GROUND = 4'd0;
	localparam logic [3:0] S_ESC = 4'd1;
	localparam logic [3:0] S_ESC_INT = 4'd2;
	localparam logic [3:0] S_CSI_ENTRY = 4'd3;
	localparam logic [3:0] S_CSI_PARAM = 4'd4;
	localparam logic [3:0] S_CSI_INT = 4'd5;
	localparam logic [3:0] S_CSI_IGN = 4'd6;
	localparam logic [3:0] S_DCS_ENTRY = 4'd7;
	localparam logic [3:0] S_DCS_PARAM = 4'd8;
	localparam logic [3:0] S_DCS_INT = 4'd9;
	localparam logic [3:0] S_DCS_PASS = 4'd10;
	localparam logic [3:0] S_DCS_IGN = 4'd11;
	localparam logic [3:0] S_OSC = 4'd12;
	localparam logic [3:0] S_STR = 4'd13;

	// datapath commands from controller
	typedef struct packed {
		logic clear;      // clear params and intermediate
		logic clr_inter;  // clear intermediate only
		logic load_inter; // hold the byte as intermediate
		logic add_digit;
		logic push;
		logic osc_clear;
		logic osc_digit;
		logic osc_seen;
		logic run_start;  // begin emitting a parameter run
		logic single;     // emit a single result
		logic [3:0] kind;
	} tesp_cmd_t;

	// datapath status to controller
	typedef struct packed {
		logic busy;       // result pending or run in progress
		logic osc_data_seen;
	} tesp_sts_t;

	// saturating multiply by ten plus digit
	function automatic logic [15:0] acc_digit(input logic [15:0] v, input logic [3:0] d);
		logic [20:0] t;
		t = {5'd0, v} * 21'd10 + {17'd0, d};
		return (t > 21'd65535) ? 16'hFFFF : t[15:0];
	endfunction

endpackage

// ----- src/tesp_ctrl.sv -----
`timescale 1ns / 1ps
module tesp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [7:0]           ch,
	input  tesp_pkg::tesp_sts_t  sts,
	output tesp_pkg::tesp_cmd_t  cmd
);

	logic [3:0] state_q;
	logic [3:0] state_d;

	logic c0, inter, fin, par, digit, csi_grp, dcs_grp;
	assign c0 = ch < 8'h20;
	assign inter = ch >= 8'h20 && ch <= 8'h2F;
	assign fin = ch >= 8'h40 && ch <= 8'h7E;
	assign par = ch >= 8'h30 && ch <= 8'h3F;
	assign digit = ch >= 8'h30 && ch <= 8'h39;
	assign csi_grp = state_q == tesp_pkg::S_CSI_ENTRY || state_q == tesp_pkg::S_CSI_PARAM ||
		state_q == tesp_pkg::S_CSI_INT;
	assign dcs_grp = state_q == tesp_pkg::S_DCS_ENTRY || state_q == tesp_pkg::S_DCS_PARAM ||
		state_q == tesp_pkg::S_DCS_INT;

	// next state and commands per byte
	always_comb begin
		state_d = state_q;
		cmd = '0;
		if (in_fire) begin
			case (state_q)
				tesp_pkg::S_GROUND: begin
					if (ch == 8'h1B) begin
						state_d = tesp_pkg::S_ESC; cmd.clr_inter = 1'b1;
					end else if (ch == 8'h9B) begin
						cmd.clear = 1'b1; state_d = tesp_pkg::S_CSI_ENTRY;
					end else if (ch == 8'h90) begin
						cmd.clear = 1'b1; state_d = tesp_pkg::S_DCS_ENTRY;
					end else if (ch == 8'h9D) begin
						cmd.osc_clear = 1'b1; state_d = tesp_pkg::S_OSC;
					end else if (ch == 8'h9C) begin
						state_d = state_q;
					end else if (ch == 8'h98 || ch == 8'h9E || ch == 8'h9F) begin
						state_d = tesp_pkg::S_STR;
					end else if (c0 || (ch >= 8'h80 && ch <= 8'h9F)) begin
						cmd.single = 1'b1; cmd.kind = tesp_pkg::K_EXEC;
					end else begin
						cmd.single = 1'b1; cmd.kind = tesp_pkg::K_PRINT;
					end
				end
				tesp_pkg::S_ESC: begin
					if (ch == 8'h5B) begin
						cmd.clear = 1'b1; state_d = tesp_pkg::S_CSI_ENTRY;
					end else if (ch == 8'h5D) begin
						cmd.osc_clear = 1'b1; state_d = tesp_pkg::S_OSC;
					end else if (ch == 8'h50) begin
						cmd.clear = 1'b1; state_d = tesp_pkg::S_DCS_ENTRY;
					end else if (ch == 8'h5F || ch == 8'h5E) begin
						state_d = tesp_pkg::S_STR;
					end else if (ch == 8'h5C) begin
						state_d = tesp_pkg::S_GROUND;
					end else if (inter) begin
						cmd.load_inter = 1'b1; state_d = tesp_pkg::S_ESC_INT;
					end else if (ch >= 8'h30 && ch <= 8'h7E) begin
						cmd.single = 1'b1; cmd.kind = tesp_pkg::K_ESC;
						state_d = tesp_pkg::S_GROUND;
					end else if (c0 && ch != 8'h1B) begin
						cmd.single = 1'b1; cmd.kind = tesp_pkg::K_EXEC;
					end else begin
						state_d = tesp_pkg::S_GROUND;
					end
				end
				tesp_pkg::S_ESC_INT: begin
					if (inter) begin
						cmd.load_inter = 1'b1;
					end else if (fin) begin
						cmd.single = 1'b1; cmd.kind = tesp_pkg::K_ESC;
						state_d = tesp_pkg::S_GROUND;
					end else if (ch == 8'h1B) begin
						state_d = tesp_pkg::S_ESC; cmd.clr_inter = 1'b1;
					end else if (c0) begin
						cmd.single = 1'b1; cmd.kind = tesp_pkg::K_EXEC;
					end else begin
						state_d = tesp_pkg::S_GROUND;
					end
				end
				tesp_pkg::S_CSI_IGN: begin
					if (fin) begin
						state_d = tesp_pkg::S_GROUND;
					end else if (ch == 8'h1B) begin
						state_d = tesp_pkg::S_ESC; cmd.clr_inter = 1'b1;
					end else if (c0) begin
						cmd.single = 1'b1; cmd.kind = tesp_pkg::K_EXEC;
					end
				end
				tesp_pkg::S_DCS_PASS: begin
					if (ch == 8'h1B) begin
						state_d = tesp_pkg::S_ESC; cmd.clr_inter = 1'b1;
					end else if (ch == 8'h9C) begin
						cmd.single = 1'b1; cmd.kind = tesp_pkg::K_UNHOOK;
						state_d = tesp_pkg::S_GROUND;
					end else begin
						cmd.single = 1'b1; cmd.kind = tesp_pkg::K_PUT;
					end
				end
				tesp_pkg::S_OSC: begin
					if (ch == 8'h1B) begin
						state_d = tesp_pkg::S_ESC; cmd.clr_inter = 1'b1;
					end else if (ch == 8'h07 || ch == 8'h9C) begin
						cmd.single = 1'b1; cmd.kind = tesp_pkg::K_OSC_END;
						state_d = tesp_pkg::S_GROUND;
					end else if ((ch >= 8'h20 && ch <= 8'h7E) || ch >= 8'h80) begin
						if (!sts.osc_data_seen && digit) begin
							cmd.osc_digit = 1'b1;
						end else if (!sts.osc_data_seen && ch == 8'h3B) begin
							cmd.osc_seen = 1'b1;
						end else begin
							cmd.osc_seen = 1'b1;
							cmd.single = 1'b1; cmd.kind = tesp_pkg::K_OSC_DATA;
						end
					end
				end
				tesp_pkg::S_DCS_IGN, tesp_pkg::S_STR: begin
					if (ch == 8'h1B) begin
						state_d = tesp_pkg::S_ESC; cmd.clr_inter = 1'b1;
					end else if (ch == 8'h9C) begin
						state_d = tesp_pkg::S_GROUND;
					end
				end
				default: begin
					if (csi_grp) begin
						if (par && state_q != tesp_pkg::S_CSI_INT) begin
							state_d = tesp_pkg::S_CSI_PARAM;
							if (digit) begin
								cmd.add_digit = 1'b1;
							end else if (ch == 8'h3B ||
								(ch == 8'h3A && state_q != tesp_pkg::S_CSI_ENTRY)) begin
								cmd.push = 1'b1;
							end else if (ch >= 8'h3C && state_q == tesp_pkg::S_CSI_ENTRY) begin
								cmd.load_inter = 1'b1;
							end else begin
								state_d = tesp_pkg::S_CSI_IGN;
							end
						end else if (inter) begin
							cmd.load_inter = 1'b1; state_d = tesp_pkg::S_CSI_INT;
						end else if (fin) begin
							cmd.push = 1'b1; cmd.run_start = 1'b1;
							cmd.kind = tesp_pkg::K_CSI; state_d = tesp_pkg::S_GROUND;
						end else if (ch == 8'h1B) begin
							state_d = tesp_pkg::S_ESC; cmd.clr_inter = 1'b1;
						end else if (c0) begin
							cmd.single = 1'b1; cmd.kind = tesp_pkg::K_EXEC;
						end else begin
							state_d = tesp_pkg::S_CSI_IGN;
						end
					end else if (dcs_grp) begin
						if (par && state_q != tesp_pkg::S_DCS_INT) begin
							state_d = tesp_pkg::S_DCS_PARAM;
							if (digit) begin
								cmd.add_digit = 1'b1;
							end else if (ch == 8'h3B) begin
								cmd.push = 1'b1;
							end
						end else if (inter) begin
							cmd.load_inter = 1'b1; state_d = tesp_pkg::S_DCS_INT;
						end else if (fin) begin
							cmd.push = 1'b1; cmd.run_start = 1'b1;
							cmd.kind = tesp_pkg::K_HOOK; state_d = tesp_pkg::S_DCS_PASS;
						end else if (ch == 8'h1B) begin
							state_d = tesp_pkg::S_ESC; cmd.clr_inter = 1'b1;
						end else if (c0) begin
							cmd.single = 1'b1; cmd.kind = tesp_pkg::K_EXEC;
						end else begin
							state_d = tesp_pkg::S_DCS_IGN;
						end
					end else begin
						state_d = tesp_pkg::S_GROUND;
					end
				end
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tesp_pkg::S_GROUND;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/tesp_dp.sv -----
`timescale 1ns / 1ps
module tesp_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [7:0]           ch,
	input  tesp_pkg::tesp_cmd_t  cmd,
	output tesp_pkg::tesp_sts_t  sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3:0]           out_kind,
	output logic [7:0]           out_code,
	output logic [7:0]           out_inter,
	output logic [15:0]          out_value,
	output logic [3:0]           out_index,
	output logic [4:0]           out_total,
	output logic                 out_last
);

	logic [15:0] store_q [tesp_pkg::PARAM_SLOTS];
	logic [tesp_pkg::PARAM_SLOTS-1:0] sval_q;   // slot written since clear
	logic [tesp_pkg::CNT_W-1:0] used_q;
	logic [7:0] inter_q;
	logic [15:0] osc_num_q;
	logic osc_seen_q;
	// run emission
	logic run_q;
	logic [tesp_pkg::SLOT_W-1:0] ridx_q;
	logic [3:0] rkind_q;
	logic [7:0] rcode_q;

	logic has_room;
	logic [tesp_pkg::SLOT_W-1:0] uslot;
	logic [15:0] cur;
	logic out_free;
	logic [15:0] rval;

	assign has_room = used_q < tesp_pkg::CNT_W'(tesp_pkg::PARAM_SLOTS);
	assign uslot = used_q[tesp_pkg::SLOT_W-1:0];
	assign cur = sval_q[uslot] ? store_q[uslot] : 16'd0;
	assign out_free = !out_valid || out_ready;
	assign rval = sval_q[ridx_q] ? store_q[ridx_q] : 16'd0;
	assign sts.busy = out_valid || run_q;
	assign sts.osc_data_seen = osc_seen_q;

	// parameter slots
	always_ff @(posedge clk) begin
		if (in_fire && cmd.add_digit && has_room) begin
			store_q[uslot] <= tesp_pkg::acc_digit(cur, ch[3:0]);
		end
	end

	// parameter control and osc state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sval_q <= '0;
			used_q <= '0;
			inter_q <= '0;
			osc_num_q <= '0;
			osc_seen_q <= 1'b0;
		end else if (in_fire) begin
			if (cmd.clear) begin
				sval_q <= '0;
				used_q <= '0;
				inter_q <= '0;
			end
			if (cmd.clr_inter || (cmd.single && cmd.kind == tesp_pkg::K_ESC)) begin
				inter_q <= '0;
			end
			if (cmd.load_inter) begin
				inter_q <= ch;
			end
			if (cmd.add_digit && has_room) begin
				sval_q[uslot] <= 1'b1;
			end
			if (cmd.push && has_room) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.osc_clear) begin
				osc_num_q <= '0;
				osc_seen_q <= 1'b0;
			end
			if (cmd.osc_digit) begin
				osc_num_q <= tesp_pkg::acc_digit(osc_num_q, ch[3:0]);
			end
			if (cmd.osc_seen) begin
				osc_seen_q <= 1'b1;
			end
		end
	end

	// output register and run sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			run_q <= 1'b0;
			ridx_q <= '0;
			rkind_q <= '0;
			rcode_q <= '0;
		end else begin
			if (in_fire && cmd.run_start) begin
				// the input only opens when the register is empty or being taken
				out_valid <= 1'b0;
				run_q <= 1'b1;
				ridx_q <= '0;
				rkind_q <= cmd.kind;
				rcode_q <= ch;
			end else if (in_fire && cmd.single) begin
				out_valid <= 1'b1;
			end else if (run_q && out_free) begin
				out_valid <= 1'b1;
				ridx_q <= ridx_q + 1'b1;
				if ({1'b0, ridx_q} + 1'b1 == used_q) run_q <= 1'b0;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_fire && cmd.single) begin
			out_kind <= cmd.kind;
			out_code <= ch;
			out_inter <= (cmd.kind == tesp_pkg::K_ESC) ? inter_q : 8'd0;
			out_value <= (cmd.kind == tesp_pkg::K_OSC_END) ? osc_num_q : 16'd0;
			out_index <= '0;
			out_total <= '0;
			out_last <= 1'b1;
		end else if (!(in_fire && cmd.run_start) && run_q && out_free) begin
			out_kind <= rkind_q;
			out_code <= rcode_q;
			out_inter <= '0;
			out_value <= rval;
			out_index <= ridx_q;
			out_total <= used_q;
			out_last <= ({1'b0, ridx_q} + 1'b1 == used_q);
		end
	end

endmodule

// ----- src/terminal_escape_sequence_parser_top.sv -----
`timescale 1ns / 1ps
// latency: a single result beat is valid the cycle after its byte is accepted
// a final byte with n parameters: run_q, then the first beat; one beat per cycle while ready
// throughput: one byte per cycle while the output drains; a final byte with n
// parameters holds the input closed until the last beat of its run is taken
// reset: arst_n asynchronous, active low; parser returns to ground, parameters cleared
module terminal_escape_sequence_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // byte_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // kind, code, inter_byte, value, param_index, param_total
	output logic        m_axis_tlast    // last
);

	tesp_pkg::tesp_cmd_t cmd;
	tesp_pkg::tesp_sts_t sts;
	logic in_fire;
	logic cmd_run_hold;
	logic [3:0] o_kind;
	logic [7:0] o_code;
	logic [7:0] o_inter;
	logic [15:0] o_value;
	logic [3:0] o_index;
	logic [4:0] o_total;

	// accept when nothing pending, or the pending beat leaves now and is the last of its run
	assign s_axis_tready = !sts.busy || (m_axis_tvalid && m_axis_tready && !cmd_run_hold);
	assign in_fire = s_axis_tvalid && s_axis_tready;

	tesp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .ch(s_axis_tdata),
		.sts(sts), .cmd(cmd)
	);

	tesp_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .ch(s_axis_tdata),
		.cmd(cmd), .sts(sts),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_kind(o_kind), .out_code(o_code), .out_inter(o_inter),
		.out_value(o_value), .out_index(o_index), .out_total(o_total),
		.out_last(m_axis_tlast)
	);

	// a run in progress keeps the input closed
	assign cmd_run_hold = m_axis_tvalid && !m_axis_tlast;

	assign m_axis_tdata = {3'd0, o_total, o_index, o_value, o_inter, o_code, o_kind};

endmodule
